/* src/rfs_pkg.sv */
// Package for the ring FIFO with search: field widths, request codes and the
// command/status bundles shared by the controller and the datapath.
// No dependencies.
package rfs_pkg;

  // Field widths
  localparam int DATA_W = 32;
  localparam int ACT_W  = 3;
  localparam int POS_W  = 6;
  localparam int CNT_W  = 7;
  localparam int OUT_W  = 48;  // data, position, count, empty, full, one pad bit

  // Capacity after reset
  localparam logic [CNT_W-1:0] CAP_RST = 7'd64;

  // Request codes
  localparam logic [ACT_W-1:0] ACT_ENQ    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DEQ    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic load;        // latch a new request, preset a failing result
    logic do_enq;      // write at tail, advance tail, count up
    logic do_deq;      // read head, advance head, count down
    logic do_peek;     // read head
    logic do_clear;    // pointers and count to zero
    logic srch_start;  // read head, set up the walk
    logic srch_step;   // compare one entry, read the next
    logic take_rdata;  // capture memory read data as result data
    logic res_ok;      // mark the result as a success
    logic out_load;    // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             empty;
    logic             full;
    logic             srch_hit;   // entry under compare matches
    logic             srch_last;  // entry under compare is the last stored one
    logic             out_free;   // output register can take a result
  } sts_t;

endpackage

/* src/rfs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/rfs_datapath.sv */
// Datapath of the ring FIFO: pointers, count, capacity register, slot memory,
// search walk and the output register. Depends on rfs_pkg and rfs_ram.
module rfs_datapath #(
  parameter int DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [rfs_pkg::ACT_W-1:0]      action_i,
  input  logic [rfs_pkg::DATA_W-1:0]     value_i,
  input  logic                           cfg_we_i,
  input  logic [rfs_pkg::CNT_W-1:0]      cfg_data_i,
  input  rfs_pkg::cmd_t                  cmd_i,
  output rfs_pkg::sts_t                  sts_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rfs_pkg::OUT_W-1:0]      out_data_o,
  output logic                           out_user_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = rfs_pkg::CNT_W;
  localparam int DW = rfs_pkg::DATA_W;
  localparam int PW = rfs_pkg::POS_W;
  // Count and walk widths follow DEPTH; the result fields are cut to their widths
  localparam int SW = $clog2(DEPTH + 1);
  localparam int KW = (SW > CW) ? SW : CW;
  localparam int EW = (AW + 1 > KW) ? AW + 1 : KW;

  logic [AW-1:0] head_q, tail_q, walk_q;
  logic [SW-1:0] stored_q, chk_q;
  logic [CW-1:0] cap_q;
  logic [KW-1:0] eff_cap;
  logic [rfs_pkg::ACT_W-1:0] act_q;
  logic [DW-1:0] val_q, res_data_q, rd_data;
  logic [PW-1:0] res_pos_q;
  logic          res_fail_q;
  logic          out_valid_q;
  logic [rfs_pkg::OUT_W-1:0] out_data_q;
  logic          out_user_q;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic          full;

  // Next pointer position, wrapping at the capacity
  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p, input logic [KW-1:0] cap);
    logic [EW-1:0] nxt;
    nxt = EW'(p) + EW'(1);
    if (nxt >= EW'(cap)) begin
      adv = '0;
    end else begin
      adv = nxt[AW-1:0];
    end
  endfunction

  // Capacity clamped to 1..DEPTH
  always_comb begin
    eff_cap = KW'(cap_q);
    if (cap_q == '0) begin
      eff_cap = KW'(1);
    end else if (EW'(cap_q) > EW'(DEPTH)) begin
      eff_cap = KW'(DEPTH);
    end
  end

  assign full = (KW'(stored_q) >= eff_cap);

  // Slot memory: write at tail, read at head or at the walk pointer
  assign rd_addr = cmd_i.srch_step ? walk_q : head_q;
  assign rd_en   = cmd_i.do_deq | cmd_i.do_peek | cmd_i.srch_start | cmd_i.srch_step;

  rfs_ram #(
    .WIDTH(DW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.do_enq),
    .waddr_i(tail_q),
    .wdata_i(val_q),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  // Queue control state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      stored_q    <= '0;
      cap_q       <= rfs_pkg::CAP_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.do_enq) begin
        tail_q   <= adv(tail_q, eff_cap);
        stored_q <= stored_q + SW'(1);
      end
      if (cmd_i.do_deq) begin
        head_q   <= adv(head_q, eff_cap);
        stored_q <= stored_q - SW'(1);
      end
      if (cmd_i.do_clear) begin
        head_q   <= '0;
        tail_q   <= '0;
        stored_q <= '0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request, result and search walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q      <= action_i;
      val_q      <= value_i;
      res_fail_q <= 1'b1;
      res_data_q <= '0;
      res_pos_q  <= '0;
    end
    if (cmd_i.res_ok) begin
      res_fail_q <= 1'b0;
    end
    if (cmd_i.take_rdata) begin
      res_data_q <= rd_data;
    end
    if (cmd_i.srch_start) begin
      walk_q <= adv(head_q, eff_cap);
      chk_q  <= '0;
    end
    if (cmd_i.srch_step) begin
      walk_q <= adv(walk_q, eff_cap);
      chk_q  <= chk_q + SW'(1);
      if (rd_data == val_q) begin
        res_pos_q <= PW'(chk_q);
      end
    end
    if (cmd_i.out_load) begin
      out_user_q <= res_fail_q;
      out_data_q <= {1'b0, full, (stored_q == '0), CW'(stored_q), res_pos_q, res_data_q};
    end
  end

  // Status to the controller
  assign sts_o.act       = act_q;
  assign sts_o.empty     = (stored_q == '0);
  assign sts_o.full      = full;
  assign sts_o.srch_hit  = (rd_data == val_q);
  assign sts_o.srch_last = ((chk_q + SW'(1)) == stored_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

  // Checks
  a_enq_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_enq |-> !full)
    else $error("enqueue issued while the queue is full");

  a_deq_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.do_deq || cmd_i.do_peek || cmd_i.srch_start) |-> (stored_q != '0))
    else $error("head read issued while the queue is empty");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken result");

  a_clear_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_clear |=> (stored_q == '0))
    else $error("count not zero after clear");

  a_rdata_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take_rdata |-> $past(cmd_i.do_deq || cmd_i.do_peek))
    else $error("read data taken without a head read");

endmodule

/* src/rfs_ctrl.sv */
// Controller of the ring FIFO: sequences one request at a time through
// execute, memory read, search walk and result hand-off. Depends on rfs_pkg.
module rfs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rfs_pkg::sts_t sts_i,
  output rfs_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_RDWAIT = 3'd2;
  localparam logic [2:0] ST_SEARCH = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        case (sts_i.act)
          rfs_pkg::ACT_ENQ: begin
            if (!sts_i.full) begin
              cmd_o.do_enq = 1'b1;
              cmd_o.res_ok = 1'b1;
            end
          end
          rfs_pkg::ACT_DEQ: begin
            if (!sts_i.empty) begin
              cmd_o.do_deq = 1'b1;
              cmd_o.res_ok = 1'b1;
              state_d      = ST_RDWAIT;
            end
          end
          rfs_pkg::ACT_PEEK: begin
            if (!sts_i.empty) begin
              cmd_o.do_peek = 1'b1;
              cmd_o.res_ok  = 1'b1;
              state_d       = ST_RDWAIT;
            end
          end
          rfs_pkg::ACT_CLEAR: begin
            cmd_o.do_clear = 1'b1;
            cmd_o.res_ok   = 1'b1;
          end
          rfs_pkg::ACT_SEARCH: begin
            if (!sts_i.empty) begin
              cmd_o.srch_start = 1'b1;
              state_d          = ST_SEARCH;
            end
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_RDWAIT: begin
        cmd_o.take_rdata = 1'b1;
        state_d          = ST_DONE;
      end
      ST_SEARCH: begin
        cmd_o.srch_step = 1'b1;
        if (sts_i.srch_hit) begin
          cmd_o.res_ok = 1'b1;
          state_d      = ST_DONE;
        end else if (sts_i.srch_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* src/ring_fifo_with_search_core.sv */
// Ring FIFO of signed 32-bit words with enqueue, dequeue, peek, clear and search.
// Each request passes the execute state, then a read wait state for dequeue and
// peek or a walk of k compared entries for search (k at most the stored count, so
// at most DEPTH), then the result hand-off; one request in flight at a time.
// The search walk reads one slot per cycle from the single memory read port.
// Reset clears pointers and count and sets capacity to 64; slot contents are kept.
module ring_fifo_with_search_core #(
  parameter int DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [2:0]  s_tuser,   // [2:0] action
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [31:0] data, [37:32] position, [44:38] count,
                                 // [45] empty_res, [46] full_res, [47] zero
  output logic        m_tuser,   // [0] status
  // Capacity register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i
);

  rfs_pkg::cmd_t cmd;
  rfs_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  rfs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_tvalid),
    .in_ready_o(s_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rfs_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .action_i   (s_tuser),
    .value_i    (s_tdata),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(m_tvalid),
    .out_ready_i(m_tready),
    .out_data_o (m_tdata),
    .out_user_o (m_tuser)
  );

endmodule
